// File: design/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FIN
  } fpa_state_e;

  // request actions
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  // allocate policies
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOFIT    = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;
  localparam logic [1:0] STS_BADIDX   = 2'd3;

  localparam logic [4:0]  CFG_RESET = 5'd10;
  localparam logic [15:0] ID_FIRST  = 16'd1;
  localparam logic [15:0] ID_LAST   = 16'hFFFF;

  // size of each partition straight after reset
  function automatic logic [31:0] init_size(input logic [31:0] idx);
    logic [31:0] val;
    case (idx)
      32'd0:   val = 32'd100;
      32'd1:   val = 32'd500;
      32'd2:   val = 32'd200;
      32'd3:   val = 32'd300;
      32'd4:   val = 32'd600;
      32'd5:   val = 32'd150;
      32'd6:   val = 32'd400;
      32'd7:   val = 32'd250;
      32'd8:   val = 32'd350;
      32'd9:   val = 32'd120;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: design/fpa_ram.sv
`default_nettype none

module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/fixed_partition_allocator_top.sv
`default_nettype none
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// request   | in_valid_i / in_ready_o        | action, policy, request_size, process_id,
//           |                                | entry_index, entry_size
// result    | out_valid_o / out_ready_i      | status, partition_index, assigned_id,
//           |                                | partition_size
// config    | cfg_we_i (no wait)             | cfg_wdata_i = partitions_in_use
//
// one item at a time, ready low from the accept edge until the result register is loaded
// load-size, unknown action and free of id zero go straight to the final state to load the result
// a scan reads one entry a cycle over the n active partitions before the final state
// next fit first folds the rover below n in ST_MOD by repeated subtraction of n
// reset clears control, occupied marks and size valid marks; no clearing pass is needed
// a stalled result does not stop the next item being taken; that item waits in its final state

module fixed_partition_allocator_top #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [1:0]  policy_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic [15:0] process_id_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [15:0] entry_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [3:0]       partition_index_o,
  output logic [15:0]      assigned_id_o,
  output logic [15:0]      partition_size_o
);

  import fpa_pkg::*;

  localparam int IDX_W = $clog2(PARTITIONS);
  localparam int CNT_W = $clog2(PARTITIONS + 1);
  localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  // control state
  fpa_state_e            state_q, state_d;
  logic [4:0]            cfg_q;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [IDX_W-1:0]      at_q, at_d;          // next address to issue
  logic [CNT_W-1:0]      cnt_q, cnt_d;        // addresses issued so far
  logic                  p_vld_q, p_vld_d;    // ram read data belongs to a scan step
  logic [IDX_W-1:0]      p_at_q, p_at_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      pick_q, pick_d;
  logic [SIZE_BITS-1:0]  pick_size_q, pick_size_d;
  logic [PARTITIONS-1:0] occ_q, occ_d;
  logic [PARTITIONS-1:0] svld_q, svld_d;      // size entry written since reset
  logic [IDX_W-1:0]      rover_q, rover_d;
  logic [15:0]           id_q, id_d;
  logic                  out_vld_q, out_vld_d;

  // request payload, held for the whole item
  logic [1:0]  act_q;
  logic [1:0]  pol_q;
  logic [15:0] need_q;
  logic [15:0] pid_q;
  logic [3:0]  eidx_q;
  logic [15:0] esize_q;

  // result register
  logic [1:0]  out_status_q;
  logic [3:0]  out_idx_q;
  logic [15:0] out_id_q;
  logic [15:0] out_size_q;

  logic                 accept;
  logic                 commit;
  logic                 scan_iss;
  logic [CNT_W-1:0]     n_cfg;
  logic [SIZE_BITS-1:0] size_rdata;
  logic [15:0]          owner_rdata;
  logic [SIZE_BITS-1:0] size_eff;
  logic                 hit;
  logic                 better;
  logic                 first_like;
  logic                 eidx_ok;
  logic                 owner_we;
  logic                 size_we;
  logic [1:0]           res_status;
  logic [3:0]           res_idx;
  logic [15:0]          res_id;
  logic [15:0]          res_size;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // out-of-range counts clamp to one and to the table depth
  always_comb begin
    if (cfg_q == 5'd0) begin
      n_cfg = CNT_W'(1);
    end else if (32'(cfg_q) > PARTITIONS) begin
      n_cfg = CNT_W'(PARTITIONS);
    end else begin
      n_cfg = CNT_W'(cfg_q);
    end
  end

  // entries never loaded read as their reset size
  assign size_eff = svld_q[p_at_q] ? size_rdata
                                   : SIZE_BITS'(init_size(32'(p_at_q)));

  // shared scan evaluation: fit test for allocate, owner match for free
  assign hit = (act_q == ACT_ALLOC)
             ? (!occ_q[p_at_q] && (CMP_W'(size_eff) >= CMP_W'(need_q)))
             : (occ_q[p_at_q] && (owner_rdata == pid_q));
  assign better = !found_q ||
                  ((pol_q == POL_BEST) ? (size_eff < pick_size_q)
                                       : (size_eff > pick_size_q));
  assign first_like = (act_q == ACT_FREE) || (pol_q == POL_FIRST) || (pol_q == POL_NEXT);
  assign eidx_ok    = (32'(eidx_q) < PARTITIONS);

  // result of the finished item
  always_comb begin
    res_status = STS_BADIDX;
    res_idx    = 4'd0;
    res_id     = 16'd0;
    res_size   = 16'd0;
    case (act_q)
      ACT_ALLOC: begin
        if (found_q) begin
          res_status = STS_OK;
          res_idx    = 4'(pick_q);
          res_id     = id_q;
          res_size   = 16'(pick_size_q);
        end else begin
          res_status = STS_NOFIT;
        end
      end
      ACT_FREE: begin
        if (found_q) begin
          res_status = STS_OK;
          res_idx    = 4'(pick_q);
          res_size   = 16'(pick_size_q);
        end else begin
          res_status = STS_NOTFOUND;
        end
      end
      ACT_LOAD: begin
        if (eidx_ok) begin
          res_status = STS_OK;
          res_idx    = eidx_q;
          res_size   = 16'(SIZE_BITS'(esize_q));
        end
      end
      default: begin
        res_status = STS_BADIDX;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    at_d        = at_q;
    cnt_d       = cnt_q;
    p_at_d      = at_q;
    found_d     = found_q;
    pick_d      = pick_q;
    pick_size_d = pick_size_q;
    occ_d       = occ_q;
    svld_d      = svld_q;
    rover_d     = rover_q;
    id_d        = id_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    scan_iss    = 1'b0;
    commit      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d     = n_cfg;
          at_d    = '0;
          cnt_d   = '0;
          found_d = 1'b0;
          case (action_i)
            ACT_ALLOC: begin
              if (policy_i == POL_NEXT) begin
                at_d    = rover_q;
                state_d = ST_MOD;
              end else begin
                state_d = ST_SCAN;
              end
            end
            ACT_FREE: begin
              state_d = (process_id_i != 16'd0) ? ST_SCAN : ST_FIN;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end

      ST_MOD: begin
        // rover may lie above a shrunk count
        if (CNT_W'(at_q) >= n_q) begin
          at_d = IDX_W'(CNT_W'(at_q) - n_q);
        end else begin
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (p_vld_q && hit && (first_like || better)) begin
          found_d     = 1'b1;
          pick_d      = p_at_q;
          pick_size_d = size_eff;
        end
        if (p_vld_q && hit && first_like) begin
          state_d = ST_FIN;
        end else if ((cnt_q == n_q) && !p_vld_q) begin
          state_d = ST_FIN;
        end else if (cnt_q < n_q) begin
          scan_iss = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
          at_d     = ((CNT_W'(at_q) + CNT_W'(1)) == n_q) ? '0 : at_q + IDX_W'(1);
        end
      end

      ST_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          commit    = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
          if ((act_q == ACT_ALLOC) && found_q) begin
            occ_d[pick_q] = 1'b1;
            id_d          = (id_q == ID_LAST) ? ID_FIRST : id_q + 16'd1;
            if (pol_q == POL_NEXT) begin
              rover_d = ((CNT_W'(pick_q) + CNT_W'(1)) == n_q) ? '0 : pick_q + IDX_W'(1);
            end
          end
          if ((act_q == ACT_FREE) && found_q) begin
            occ_d[pick_q] = 1'b0;
          end
          if ((act_q == ACT_LOAD) && eidx_ok) begin
            svld_d[IDX_W'(eidx_q)] = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign p_vld_d  = scan_iss && (state_d == ST_SCAN);
  assign owner_we = commit && (act_q == ACT_ALLOC) && found_q;
  assign size_we  = commit && (act_q == ACT_LOAD) && eidx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CFG_RESET;
      n_q       <= CNT_W'(1);
      at_q      <= '0;
      cnt_q     <= '0;
      p_vld_q   <= 1'b0;
      p_at_q    <= '0;
      found_q   <= 1'b0;
      pick_q    <= '0;
      occ_q     <= '0;
      svld_q    <= '0;
      rover_q   <= '0;
      id_q      <= ID_FIRST;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      n_q       <= n_d;
      at_q      <= at_d;
      cnt_q     <= cnt_d;
      p_vld_q   <= p_vld_d;
      p_at_q    <= p_at_d;
      found_q   <= found_d;
      pick_q    <= pick_d;
      occ_q     <= occ_d;
      svld_q    <= svld_d;
      rover_q   <= rover_d;
      id_q      <= id_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pick_size_q <= pick_size_d;
    if (accept) begin
      act_q   <= action_i;
      pol_q   <= policy_i;
      need_q  <= request_size_i;
      pid_q   <= process_id_i;
      eidx_q  <= entry_index_i;
      esize_q <= entry_size_i;
    end
    if (commit) begin
      out_status_q <= res_status;
      out_idx_q    <= res_idx;
      out_id_q     <= res_id;
      out_size_q   <= res_size;
    end
  end

  // partition sizes
  fpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (PARTITIONS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (IDX_W'(eidx_q)),
    .wdata_i (SIZE_BITS'(esize_q)),
    .re_i    (scan_iss),
    .raddr_i (at_q),
    .rdata_o (size_rdata)
  );

  // owner ids, used only behind a set occupied mark
  fpa_ram #(
    .WIDTH (16),
    .DEPTH (PARTITIONS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .waddr_i (pick_q),
    .wdata_i (id_q),
    .re_i    (scan_iss),
    .raddr_i (at_q),
    .rdata_o (owner_rdata)
  );

  assign out_valid_o       = out_vld_q;
  assign status_o          = out_status_q;
  assign partition_index_o = out_idx_q;
  assign assigned_id_o     = out_id_q;
  assign partition_size_o  = out_size_q;

endmodule

`default_nettype wire

// File: design/fpa_checker.sv
`default_nettype none

module fpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [3:0]  partition_index_o,
  input wire logic [15:0] assigned_id_o,
  input wire logic [15:0] partition_size_o
);

  import fpa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(partition_index_o) && $stable(assigned_id_o) && $stable(partition_size_o))
    else $error("result changed while stalled");

  // failed requests report zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STS_OK) |->
    (partition_index_o == 4'd0) && (assigned_id_o == 16'd0) && (partition_size_o == 16'd0))
    else $error("failed result carries data");

  // busy once an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after accept");

  // no result before the item has been worked on
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after accept");

endmodule

bind fixed_partition_allocator_top fpa_checker u_fpa_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
  import fpa_pkg::*;

  // action code 3 has no name in the package: the block answers it as an index fault
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // cycles without any handshake before the run is given up
  localparam int QUIET_LIMIT = 2000;
  // settle time after the last answer: worst scan plus rover fold, rounded up
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  policy;
    logic [15:0] request_size;
    logic [15:0] process_id;
    logic [3:0]  entry_index;
    logic [15:0] entry_size;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  partition_index;
    logic [15:0] assigned_id;
    logic [15:0] partition_size;
  } alloc_rsp_t;

  // clock, reset and block ports; the inputs are known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = 5'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = 2'd0;
  logic [1:0]  policy_i = 2'd0;
  logic [15:0] request_size_i = 16'd0;
  logic [15:0] process_id_i = 16'd0;
  logic [3:0]  entry_index_i = 4'd0;
  logic [15:0] entry_size_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  partition_index_o;
  logic [15:0] assigned_id_o;
  logic [15:0] partition_size_o;

  // requests not yet offered, and the answers the table model gives for accepted ones
  alloc_req_t req_q[$];
  alloc_rsp_t grant_q[$];

  // own copy of the partition table
  logic [15:0] part_size [16];
  bit          part_busy [16];
  logic [15:0] part_owner [16];
  logic [3:0]  rover;
  logic [15:0] next_id;
  logic [4:0]  part_count;

  // handshake bookkeeping
  bit          req_taken = 1'b0;
  bit          idle_on = 1'b1;
  int          gap_left = 0;
  int          stall_left = 0;
  int          fail_count = 0;
  alloc_req_t  nxt_req;
  alloc_rsp_t  rsp_got;
  alloc_rsp_t  rsp_want;

  fixed_partition_allocator_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .policy_i          (policy_i),
    .request_size_i    (request_size_i),
    .process_id_i      (process_id_i),
    .entry_index_i     (entry_index_i),
    .entry_size_i      (entry_size_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .partition_index_o (partition_index_o),
    .assigned_id_o     (assigned_id_o),
    .partition_size_o  (partition_size_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // free and large enough
  function automatic bit slot_fits(int k, logic [15:0] need);
    return !part_busy[k] && (part_size[k] >= need);
  endfunction

  // answer of the allocator to one request, updating the table copy
  function automatic alloc_rsp_t table_answer(alloc_req_t rq);
    alloc_rsp_t rs;
    int n;
    int pick;
    int k;
    int at;
    int start;
    rs = '0;
    pick = -1;
    // register value zero acts as one, anything above the table acts as the full table
    if (part_count == 5'd0) n = 1;
    else if (part_count > 5'd16) n = 16;
    else n = part_count;
    case (rq.action)
      ACT_ALLOC: begin
        case (rq.policy)
          POL_FIRST: begin
            for (k = 0; k < n; k++)
              if (pick < 0 && slot_fits(k, rq.request_size)) pick = k;
          end
          POL_BEST, POL_WORST: begin
            // strict compare keeps the lowest index on ties
            for (k = 0; k < n; k++) begin
              if (slot_fits(k, rq.request_size)) begin
                if (pick < 0 ||
                    (rq.policy == POL_BEST && part_size[k] < part_size[pick]) ||
                    (rq.policy == POL_WORST && part_size[k] > part_size[pick]))
                  pick = k;
              end
            end
          end
          default: begin
            // next fit: a rover left above n after a shrink starts at rover mod n
            start = rover % n;
            for (k = 0; k < n; k++) begin
              at = (start + k) % n;
              if (pick < 0 && slot_fits(at, rq.request_size)) pick = at;
            end
            if (pick >= 0) rover = 4'((pick + 1) % n);
          end
        endcase
        if (pick < 0) begin
          rs.status = STS_NOFIT;
        end else begin
          part_busy[pick] = 1'b1;
          part_owner[pick] = next_id;
          rs.assigned_id = next_id;
          rs.partition_index = 4'(pick);
          rs.partition_size = part_size[pick];
          next_id = (next_id == ID_LAST) ? ID_FIRST : next_id + 16'd1;
        end
      end
      ACT_FREE: begin
        rs.status = STS_NOTFOUND;
        // id zero never matches
        if (rq.process_id != 16'd0) begin
          for (k = 0; k < n; k++) begin
            if (pick < 0 && part_busy[k] && part_owner[k] == rq.process_id) pick = k;
          end
        end
        if (pick >= 0) begin
          part_busy[pick] = 1'b0;
          rs.status = STS_OK;
          rs.partition_index = 4'(pick);
          rs.partition_size = part_size[pick];
        end
      end
      ACT_LOAD: begin
        // a 4-bit index always lies inside a 16-entry table
        part_size[rq.entry_index] = rq.entry_size;
        rs.partition_index = rq.entry_index;
        rs.partition_size = rq.entry_size;
      end
      default: begin
        rs.status = STS_BADIDX;
      end
    endcase
    return rs;
  endfunction

  function automatic alloc_req_t mk_req(logic [1:0] act, logic [1:0] pol, logic [15:0] need,
                                        logic [15:0] pid, logic [3:0] idx, logic [15:0] sz);
    alloc_req_t rq;
    rq.action = act;
    rq.policy = pol;
    rq.request_size = need;
    rq.process_id = pid;
    rq.entry_index = idx;
    rq.entry_size = sz;
    return rq;
  endfunction

  // wait until every request is in and every answer is out, then let the block settle
  task automatic wait_until_quiet();
    while (req_q.size() != 0 || grant_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only ever done while the block is idle
  task automatic set_part_count(logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one setting of the register followed by a stream of mostly sensible requests
  task automatic run_random_phase(logic [4:0] cfg_val, int count);
    alloc_req_t rq;
    int i;
    int roll;
    int k;
    int tries;
    wait_until_quiet();
    set_part_count(cfg_val);
    for (i = 0; i < count; i++) begin
      // keep the queue short so free targets come from a current view of the table
      while (req_q.size() >= 2) @(posedge clk_i);
      rq.action = ACT_ALLOC;
      rq.policy = 2'($urandom_range(0, 3));
      rq.request_size = 16'($urandom);
      rq.process_id = 16'($urandom);
      rq.entry_index = 4'($urandom);
      rq.entry_size = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        case ($urandom_range(0, 9))
          0: rq.request_size = 16'd0;
          1: rq.request_size = 16'hFFFF;
          2: ;
          default: rq.request_size = 16'($urandom_range(0, 650));
        endcase
      end else if (roll < 80) begin
        rq.action = ACT_FREE;
        if ($urandom_range(0, 3) != 0) begin
          // release someone who actually holds a partition
          k = $urandom_range(0, 15);
          for (tries = 0; tries < 16 && !part_busy[k]; tries++) k = (k + 1) % 16;
          if (part_busy[k]) rq.process_id = part_owner[k];
        end else if ($urandom_range(0, 3) == 0) begin
          rq.process_id = 16'd0;
        end
      end else if (roll < 95) begin
        rq.action = ACT_LOAD;
        case ($urandom_range(0, 7))
          0: rq.entry_size = 16'd0;
          1: rq.entry_size = 16'hFFFF;
          2: ;
          default: rq.entry_size = 16'($urandom_range(0, 700));
        endcase
      end else begin
        rq.action = ACT_SPARE;
      end
      req_q.push_back(rq);
    end
  endtask

  // request driver: new item at the falling edge once the previous one has been taken
  always @(negedge clk_i) begin : req_driver
    if (in_valid_i && !req_taken) begin
      // offered item not taken yet, hold it
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left = gap_left - 1;
    end else if (rst_ni && req_q.size() != 0) begin
      nxt_req = req_q.pop_front();
      action_i <= nxt_req.action;
      policy_i <= nxt_req.policy;
      request_size_i <= nxt_req.request_size;
      process_id_i <= nxt_req.process_id;
      entry_index_i <= nxt_req.entry_index;
      entry_size_i <= nxt_req.entry_size;
      in_valid_i <= 1'b1;
      // the gap opens after this item has gone in
      if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 12);
    end else begin
      in_valid_i <= 1'b0;
    end
    req_taken = 1'b0;
  end

  // accepted items and register writes feed the table model
  always @(posedge clk_i) begin : req_tracker
    alloc_req_t rq;
    if (rst_ni && cfg_we_i) part_count = cfg_wdata_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      rq.action = action_i;
      rq.policy = policy_i;
      rq.request_size = request_size_i;
      rq.process_id = process_id_i;
      rq.entry_index = entry_index_i;
      rq.entry_size = entry_size_i;
      grant_q.push_back(table_answer(rq));
      req_taken = 1'b1;
    end
  end

  // random result stalls, started only while idle_on is set
  always @(negedge clk_i) begin : rsp_ready_gen
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // every accepted result against the oldest answer of the model
  always @(posedge clk_i) begin : rsp_monitor
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsp_got.status = status_o;
      rsp_got.partition_index = partition_index_o;
      rsp_got.assigned_id = assigned_id_o;
      rsp_got.partition_size = partition_size_o;
      if (grant_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: status %0d index %0d id %0d size %0d",
                 $time, rsp_got.status, rsp_got.partition_index, rsp_got.assigned_id,
                 rsp_got.partition_size);
        fail_count++;
      end else begin
        rsp_want = grant_q.pop_front();
        if (rsp_got !== rsp_want) begin
          $display("%0t: mismatch, expected status %0d index %0d id %0d size %0d",
                   $time, rsp_want.status, rsp_want.partition_index, rsp_want.assigned_id,
                   rsp_want.partition_size);
          $display("%0t:           actual   status %0d index %0d id %0d size %0d",
                   $time, rsp_got.status, rsp_got.partition_index, rsp_got.assigned_id,
                   rsp_got.partition_size);
          fail_count++;
        end
      end
    end
  end

  // give up when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int k;
    int i;
    int pairs;
    logic [15:0] gid;

    // table copy as it stands after reset
    for (k = 0; k < 16; k++) begin
      part_size[k] = 16'd0;
      part_busy[k] = 1'b0;
      part_owner[k] = 16'd0;
    end
    part_size[0] = 16'd100;
    part_size[1] = 16'd500;
    part_size[2] = 16'd200;
    part_size[3] = 16'd300;
    part_size[4] = 16'd600;
    part_size[5] = 16'd150;
    part_size[6] = 16'd400;
    part_size[7] = 16'd250;
    part_size[8] = 16'd350;
    part_size[9] = 16'd120;
    rover = 4'd0;
    next_id = ID_FIRST;
    part_count = CFG_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset setting of ten partitions
    req_q.push_back(mk_req(ACT_ALLOC, POL_FIRST, 16'd0, 16'h1234, 4'd0, 16'd0));
    req_q.push_back(mk_req(ACT_ALLOC, POL_BEST, 16'd260, 16'd0, 4'd0, 16'd0));
    req_q.push_back(mk_req(ACT_ALLOC, POL_WORST, 16'd1, 16'd0, 4'd0, 16'd0));
    req_q.push_back(mk_req(ACT_ALLOC, POL_NEXT, 16'd0, 16'd0, 4'd0, 16'd0));
    // nothing is that large
    req_q.push_back(mk_req(ACT_ALLOC, POL_FIRST, 16'hFFFF, 16'd0, 4'd0, 16'd0));
    // id zero never matches, unknown id neither; id 2 is then freed
    req_q.push_back(mk_req(ACT_FREE, POL_FIRST, 16'd0, 16'd0, 4'd0, 16'd0));
    req_q.push_back(mk_req(ACT_FREE, POL_FIRST, 16'd0, 16'hFFFF, 4'd0, 16'd0));
    req_q.push_back(mk_req(ACT_FREE, POL_FIRST, 16'd0, 16'd2, 4'd0, 16'd0));
    // loading above the searched range is allowed
    req_q.push_back(mk_req(ACT_LOAD, POL_FIRST, 16'd0, 16'd0, 4'd15, 16'hFFFF));
    // best fit tie between entries 3 and 5
    req_q.push_back(mk_req(ACT_LOAD, POL_FIRST, 16'd0, 16'd0, 4'd5, 16'd300));
    req_q.push_back(mk_req(ACT_ALLOC, POL_BEST, 16'd300, 16'd0, 4'd0, 16'd0));
    // worst fit tie between entries 6 and 8
    req_q.push_back(mk_req(ACT_LOAD, POL_FIRST, 16'd0, 16'd0, 4'd6, 16'hFFFF));
    req_q.push_back(mk_req(ACT_LOAD, POL_FIRST, 16'd0, 16'd0, 4'd8, 16'hFFFF));
    req_q.push_back(mk_req(ACT_ALLOC, POL_WORST, 16'd0, 16'd0, 4'd0, 16'd0));
    // resize an occupied partition, then free it and see the new size
    req_q.push_back(mk_req(ACT_LOAD, POL_FIRST, 16'd0, 16'd0, 4'd0, 16'd7));
    req_q.push_back(mk_req(ACT_FREE, POL_FIRST, 16'd0, 16'd1, 4'd0, 16'd0));
    // next fit walks the rover round and wraps past the top of the range
    for (k = 0; k < 6; k++)
      req_q.push_back(mk_req(ACT_ALLOC, POL_NEXT, 16'd0, 16'd0, 4'd0, 16'd0));
    req_q.push_back(mk_req(ACT_SPARE, POL_NEXT, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF));
    req_q.push_back(mk_req(ACT_LOAD, POL_FIRST, 16'd0, 16'd0, 4'd0, 16'd0));

    // random phases over several settings, out-of-range values included
    run_random_phase(5'd16, 120);
    run_random_phase(5'd5, 120);
    run_random_phase(5'd0, 120);
    run_random_phase(5'd31, 120);
    run_random_phase(5'd1, 120);
    run_random_phase(5'd17, 120);
    run_random_phase(5'd2, 120);
    run_random_phase(5'd12, 120);

    // from here on both sides run flat out
    idle_on = 1'b0;

    // empty the whole table so entry 0 is free for the alloc and free run
    wait_until_quiet();
    set_part_count(5'd16);
    for (k = 0; k < 16; k++) begin
      if (part_busy[k])
        req_q.push_back(mk_req(ACT_FREE, POL_FIRST, 16'd0, part_owner[k], 4'd0, 16'd0));
    end

    // allocate and free back to back on a single partition
    wait_until_quiet();
    set_part_count(5'd1);
    gid = next_id;
    pairs = 40;
    for (i = 0; i < pairs; i++) begin
      while (req_q.size() >= 2) @(posedge clk_i);
      req_q.push_back(mk_req(ACT_ALLOC, 2'($urandom_range(0, 3)), 16'd0, 16'($urandom),
                             4'($urandom), 16'($urandom)));
      req_q.push_back(mk_req(ACT_FREE, 2'($urandom_range(0, 3)), 16'($urandom), gid,
                             4'($urandom), 16'($urandom)));
      gid = (gid == ID_LAST) ? ID_FIRST : gid + 16'd1;
    end

    run_random_phase(5'd16, 40);

    wait_until_quiet();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/fpa_pkg.sv
design/fpa_ram.sv
design/fixed_partition_allocator_top.sv
design/fpa_checker.sv
tb/tb_top.sv
